### design/assert_macros.svh
// Assertion macros used by the checker file fcpm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while reset is held.
`define FCPM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while reset is held.
`define FCPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/fcpm_pkg.sv
`timescale 1ns / 1ps

package fcpm_pkg;

	localparam int PALETTE_SIZE = 234;
	localparam int FULL_SCALE   = 1024;
	localparam int COLOR_SEGS   = 30;
	localparam int GRAY_SEGS    = 31;

	localparam int SAMPLE_W = 16;
	localparam int IDX_W    = 8;
	localparam int CH_W     = 8;
	localparam int SCALE_W  = 13;
	localparam int NUM_W    = 21;
	localparam int QUO_W    = 13;
	localparam int SEG_W    = 5;
	localparam int REM_W    = 8;
	localparam int PROD_W   = 16;
	localparam int NUM_CH   = 3;

	localparam int COLOR_SCALE = COLOR_SEGS * PALETTE_SIZE;
	localparam int GRAY_SCALE  = GRAY_SEGS * PALETTE_SIZE;

	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = 17;
	localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + PALETTE_SIZE - 1) / PALETTE_SIZE;

	localparam int DIV_STEPS_MAX = 4;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [IDX_W-1:0] LOW_RESET  = '0;
	localparam logic [IDX_W-1:0] HIGH_RESET = IDX_W'(PALETTE_SIZE);

	typedef enum logic [1:0] {
		REG_GRAY_MODE      = 2'd0,
		REG_LOW_THRESHOLD  = 2'd1,
		REG_HIGH_THRESHOLD = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		CLS_START,
		CLS_END,
		CLS_MID
	} pix_class_t;

	typedef struct packed {
		logic             gray;
		pix_class_t       cls;
		logic [IDX_W-1:0] idx;
	} side_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} div_part_t;

	// Red in the top byte, blue in the bottom byte. The last entry repeats the end colour.
	localparam logic [3*CH_W-1:0] COLOR_ROM [0:31] = '{
		{8'd0, 8'd0, 8'd0},     {8'd70, 8'd0, 8'd90},    {8'd87, 8'd0, 8'd114},
		{8'd74, 8'd0, 8'd138},  {8'd60, 8'd0, 8'd160},   {8'd0, 8'd0, 8'd170},
		{8'd0, 8'd0, 8'd200},   {8'd0, 8'd0, 8'd220},    {8'd0, 8'd0, 8'd255},
		{8'd0, 8'd70, 8'd255},  {8'd0, 8'd150, 8'd255},  {8'd0, 8'd200, 8'd255},
		{8'd0, 8'd220, 8'd255}, {8'd0, 8'd255, 8'd255},  {8'd0, 8'd255, 8'd180},
		{8'd0, 8'd255, 8'd150}, {8'd0, 8'd255, 8'd130},  {8'd0, 8'd255, 8'd0},
		{8'd135, 8'd255, 8'd0}, {8'd173, 8'd255, 8'd0},  {8'd210, 8'd255, 8'd0},
		{8'd255, 8'd255, 8'd0}, {8'd255, 8'd234, 8'd0},  {8'd255, 8'd210, 8'd0},
		{8'd255, 8'd181, 8'd0}, {8'd255, 8'd140, 8'd0},  {8'd255, 8'd90, 8'd0},
		{8'd255, 8'd0, 8'd0},   {8'd255, 8'd0, 8'd100},  {8'd255, 8'd0, 8'd155},
		{8'd255, 8'd0, 8'd255}, {8'd255, 8'd0, 8'd255}
	};

	localparam logic [CH_W-1:0] GRAY_ROM [0:31] = '{
		8'd255, 8'd250, 8'd245, 8'd240, 8'd238, 8'd236, 8'd233, 8'd230,
		8'd227, 8'd224, 8'd218, 8'd212, 8'd206, 8'd199, 8'd192, 8'd184,
		8'd176, 8'd168, 8'd160, 8'd152, 8'd144, 8'd136, 8'd128, 8'd122,
		8'd116, 8'd109, 8'd102, 8'd89,  8'd76,  8'd63,  8'd50,  8'd0
	};

	// Restoring division steps for quotient bits hi down to hi-n+1.
	function automatic div_part_t div_bits(input div_part_t part, input logic [IDX_W-1:0] den,
			input int hi, input int n);
		div_part_t        res;
		logic [NUM_W-1:0] dsh;
		res = part;
		for (int k = 0; k < DIV_STEPS_MAX; k++) begin
			if (k < n) begin
				dsh = NUM_W'(den) << (hi - k);
				if (res.rem >= dsh) begin
					res.rem = res.rem - dsh;
					res.quo[hi - k] = 1'b1;
				end
			end
		end
		return res;
	endfunction

endpackage

### design/fcpm_front.sv
`timescale 1ns / 1ps

module fcpm_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [fcpm_pkg::SAMPLE_W-1:0] sample,
	input  logic                               gray_mode,
	input  logic [fcpm_pkg::IDX_W-1:0]         low_threshold,
	input  logic [fcpm_pkg::IDX_W-1:0]         high_threshold,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [fcpm_pkg::NUM_W-1:0]         num,
	output logic [fcpm_pkg::IDX_W-1:0]         den,
	output fcpm_pkg::side_t                    side
);
	import fcpm_pkg::*;

	localparam int SCALED_W = SAMPLE_W - 1 + IDX_W;

	logic                valid_s1, valid_s2;
	logic                en_s1, en_s2;
	logic [SCALED_W-1:0] scaled, quot;
	logic [IDX_W-1:0]    idx_d, idx_s1;
	logic                gray_s1;
	pix_class_t          cls_d;
	logic [IDX_W-1:0]    diff;
	logic [SCALE_W-1:0]  scale;
	logic [NUM_W-1:0]    num_d, num_s2;
	logic [IDX_W-1:0]    den_s2;
	side_t               side_s2;

	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_comb begin
		scaled = SCALED_W'(sample[SAMPLE_W-2:0]) * SCALED_W'(PALETTE_SIZE);
		quot   = SCALED_W'(scaled / FULL_SCALE);
		if (sample[SAMPLE_W-1] || sample == '0) begin
			idx_d = '0;
		end else if (quot > SCALED_W'(PALETTE_SIZE)) begin
			idx_d = IDX_W'(PALETTE_SIZE);
		end else begin
			idx_d = quot[IDX_W-1:0];
		end
	end

	always_comb begin
		if (idx_s1 < IDX_W'(PALETTE_SIZE) && idx_s1 <= low_threshold) begin
			cls_d = CLS_START;
		end else if (idx_s1 >= IDX_W'(PALETTE_SIZE) || idx_s1 >= high_threshold) begin
			cls_d = CLS_END;
		end else begin
			cls_d = CLS_MID;
		end
		diff  = idx_s1 - low_threshold;
		scale = gray_s1 ? SCALE_W'(GRAY_SCALE) : SCALE_W'(COLOR_SCALE);
		num_d = (cls_d == CLS_MID) ? NUM_W'(diff) * NUM_W'(scale) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			idx_s1  <= idx_d;
			gray_s1 <= gray_mode;
		end
		if (en_s2) begin
			num_s2       <= num_d;
			den_s2       <= high_threshold - low_threshold;
			side_s2.gray <= gray_s1;
			side_s2.cls  <= cls_d;
			side_s2.idx  <= idx_s1;
		end
	end

	assign out_valid = valid_s2;
	assign num       = num_s2;
	assign den       = den_s2;
	assign side      = side_s2;

endmodule

### design/fcpm_div.sv
`timescale 1ns / 1ps

module fcpm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [fcpm_pkg::NUM_W-1:0] num,
	input  logic [fcpm_pkg::IDX_W-1:0] den,
	input  fcpm_pkg::side_t            in_side,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [fcpm_pkg::QUO_W-1:0] quo,
	output fcpm_pkg::side_t            out_side
);
	import fcpm_pkg::*;

	localparam int N2  = 3;
	localparam int N3  = 3;
	localparam int N4  = 3;
	localparam int N1  = QUO_W - N2 - N3 - N4;
	localparam int HI1 = QUO_W - 1;
	localparam int HI2 = HI1 - N1;
	localparam int HI3 = HI2 - N2;
	localparam int HI4 = HI3 - N3;

	logic             valid_s1, valid_s2, valid_s3, valid_s4;
	logic             en_s1, en_s2, en_s3, en_s4;
	div_part_t        start, part_s1, part_s2, part_s3, part_s4;
	logic [IDX_W-1:0] den_s1, den_s2, den_s3;
	side_t            side_s1, side_s2, side_s3, side_s4;

	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	assign start.rem = num;
	assign start.quo = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			part_s1 <= div_bits(start, den, HI1, N1);
			den_s1  <= den;
			side_s1 <= in_side;
		end
		if (en_s2) begin
			part_s2 <= div_bits(part_s1, den_s1, HI2, N2);
			den_s2  <= den_s1;
			side_s2 <= side_s1;
		end
		if (en_s3) begin
			part_s3 <= div_bits(part_s2, den_s2, HI3, N3);
			den_s3  <= den_s2;
			side_s3 <= side_s2;
		end
		if (en_s4) begin
			part_s4 <= div_bits(part_s3, den_s3, HI4, N4);
			side_s4 <= side_s3;
		end
	end

	assign out_valid = valid_s4;
	assign quo       = part_s4.quo;
	assign out_side  = side_s4;

endmodule

### design/fcpm_blend.sv
`timescale 1ns / 1ps

module fcpm_blend (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [fcpm_pkg::QUO_W-1:0] quo,
	input  fcpm_pkg::side_t            side,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [fcpm_pkg::CH_W-1:0]  red,
	output logic [fcpm_pkg::CH_W-1:0]  green,
	output logic [fcpm_pkg::CH_W-1:0]  blue,
	output logic [fcpm_pkg::IDX_W-1:0] color_index
);
	import fcpm_pkg::*;

	localparam int WIDE_W = PROD_W + RECIP_W;

	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	logic              en_s1, en_s2, en_s3, en_s4;
	logic [QUO_W-1:0]  rest;
	logic [SEG_W-1:0]  seg_d, segs_m1, seg_s1, seg_nx;
	logic [REM_W-1:0]  rem_s1, weight;
	side_t             side_s1, side_s2, side_s3, side_s4;
	logic [CH_W-1:0]   lo_val [NUM_CH];
	logic [CH_W-1:0]   hi_val [NUM_CH];
	logic [PROD_W-1:0] prod_a_d [NUM_CH];
	logic [PROD_W-1:0] prod_b_d [NUM_CH];
	logic [PROD_W-1:0] prod_a_s2 [NUM_CH];
	logic [PROD_W-1:0] prod_b_s2 [NUM_CH];
	logic [WIDE_W-1:0] wide_a [NUM_CH];
	logic [WIDE_W-1:0] wide_b [NUM_CH];
	logic [CH_W-1:0]   term_a_s3 [NUM_CH];
	logic [CH_W-1:0]   term_b_s3 [NUM_CH];
	logic [CH_W-1:0]   start_col [NUM_CH];
	logic [CH_W-1:0]   end_col [NUM_CH];
	logic [CH_W-1:0]   col_d [NUM_CH];
	logic [CH_W-1:0]   col_s4 [NUM_CH];

	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	// Segment and remainder of the scaled position.
	always_comb begin
		rest  = quo;
		seg_d = '0;
		for (int k = SEG_W - 1; k >= 0; k--) begin
			if (rest >= (QUO_W'(PALETTE_SIZE) << k)) begin
				rest     = rest - (QUO_W'(PALETTE_SIZE) << k);
				seg_d[k] = 1'b1;
			end
		end
		segs_m1 = side.gray ? SEG_W'(GRAY_SEGS - 1) : SEG_W'(COLOR_SEGS - 1);
		if (seg_d > segs_m1) seg_d = segs_m1;
	end

	always_comb begin
		seg_nx = seg_s1 + SEG_W'(1);
		weight = REM_W'(PALETTE_SIZE) - rem_s1;
		for (int c = 0; c < NUM_CH; c++) begin
			lo_val[c]   = side_s1.gray ? GRAY_ROM[seg_s1]
			                           : COLOR_ROM[seg_s1][(NUM_CH-1-c)*CH_W +: CH_W];
			hi_val[c]   = side_s1.gray ? GRAY_ROM[seg_nx]
			                           : COLOR_ROM[seg_nx][(NUM_CH-1-c)*CH_W +: CH_W];
			prod_a_d[c] = PROD_W'(lo_val[c]) * PROD_W'(weight);
			prod_b_d[c] = PROD_W'(hi_val[c]) * PROD_W'(rem_s1);
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			wide_a[c] = WIDE_W'(prod_a_s2[c]) * WIDE_W'(RECIP_MUL);
			wide_b[c] = WIDE_W'(prod_b_s2[c]) * WIDE_W'(RECIP_MUL);
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			start_col[c] = side_s3.gray ? GRAY_ROM[0]
			                            : COLOR_ROM[0][(NUM_CH-1-c)*CH_W +: CH_W];
			end_col[c]   = side_s3.gray ? GRAY_ROM[GRAY_SEGS]
			                            : COLOR_ROM[COLOR_SEGS][(NUM_CH-1-c)*CH_W +: CH_W];
			case (side_s3.cls)
				CLS_START: col_d[c] = start_col[c];
				CLS_END:   col_d[c] = end_col[c];
				CLS_MID:   col_d[c] = term_a_s3[c] + term_b_s3[c];
				default:   col_d[c] = end_col[c];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			seg_s1  <= seg_d;
			rem_s1  <= rest[REM_W-1:0];
			side_s1 <= side;
		end
		if (en_s2) begin
			prod_a_s2 <= prod_a_d;
			prod_b_s2 <= prod_b_d;
			side_s2   <= side_s1;
		end
		if (en_s3) begin
			for (int c = 0; c < NUM_CH; c++) begin
				term_a_s3[c] <= wide_a[c][RECIP_SHIFT +: CH_W];
				term_b_s3[c] <= wide_b[c][RECIP_SHIFT +: CH_W];
			end
			side_s3 <= side_s2;
		end
		if (en_s4) begin
			col_s4  <= col_d;
			side_s4 <= side_s3;
		end
	end

	assign out_valid   = valid_s4;
	assign red         = col_s4[0];
	assign green       = col_s4[1];
	assign blue        = col_s4[2];
	assign color_index = side_s4.idx;

endmodule

### design/false_color_pixel_mapper.sv
`timescale 1ns / 1ps
// An accepted sample passes in order through the front, divider and blend stages, and
// its result is presented from the last blend stage, which is the output register.
// Throughput: one sample per clock; ten stages (two front, four divider, four blend)
// each hold one sample, and a stall at the output holds every full stage behind it while
// empty stages still fill. Reset clears all stage valid bits and sets gray_mode to 0,
// low_threshold to 0 and high_threshold to 234. There is no memory and no clearing pass.

module false_color_pixel_mapper (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [fcpm_pkg::PADDR_W-1:0]         paddr,
	input  logic [fcpm_pkg::PDATA_W-1:0]         pwdata,
	output logic [fcpm_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  logic signed [fcpm_pkg::SAMPLE_W-1:0] sample,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic [fcpm_pkg::CH_W-1:0]            red,
	output logic [fcpm_pkg::CH_W-1:0]            green,
	output logic [fcpm_pkg::CH_W-1:0]            blue,
	output logic [fcpm_pkg::IDX_W-1:0]           color_index
);
	import fcpm_pkg::*;

	logic             gray_mode_q;
	logic [IDX_W-1:0] low_threshold_q, high_threshold_q;
	logic             wr_en;

	logic             front_valid, front_ready;
	logic [NUM_W-1:0] front_num;
	logic [IDX_W-1:0] front_den;
	side_t            front_side;

	logic             div_valid, div_ready;
	logic [QUO_W-1:0] div_quo;
	side_t            div_side;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_mode_q      <= 1'b0;
			low_threshold_q  <= LOW_RESET;
			high_threshold_q <= HIGH_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_GRAY_MODE:      gray_mode_q      <= pwdata[0];
				REG_LOW_THRESHOLD:  low_threshold_q  <= pwdata[IDX_W-1:0];
				REG_HIGH_THRESHOLD: high_threshold_q <= pwdata[IDX_W-1:0];
				default:            ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_GRAY_MODE:      prdata = PDATA_W'(gray_mode_q);
			REG_LOW_THRESHOLD:  prdata = PDATA_W'(low_threshold_q);
			REG_HIGH_THRESHOLD: prdata = PDATA_W'(high_threshold_q);
			default:            prdata = '0;
		endcase
	end

	fcpm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (sample_valid),
		.in_ready       (sample_ready),
		.sample         (sample),
		.gray_mode      (gray_mode_q),
		.low_threshold  (low_threshold_q),
		.high_threshold (high_threshold_q),
		.out_valid      (front_valid),
		.out_ready      (front_ready),
		.num            (front_num),
		.den            (front_den),
		.side           (front_side)
	);

	fcpm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.num       (front_num),
		.den       (front_den),
		.in_side   (front_side),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.quo       (div_quo),
		.out_side  (div_side)
	);

	fcpm_blend u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (div_valid),
		.in_ready    (div_ready),
		.quo         (div_quo),
		.side        (div_side),
		.out_valid   (result_valid),
		.out_ready   (result_ready),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.color_index (color_index)
	);

endmodule

### design/fcpm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fcpm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       result_valid,
	input logic                       result_ready,
	input logic [fcpm_pkg::CH_W-1:0]  red,
	input logic [fcpm_pkg::CH_W-1:0]  green,
	input logic [fcpm_pkg::CH_W-1:0]  blue,
	input logic [fcpm_pkg::IDX_W-1:0] color_index
);
	import fcpm_pkg::*;

	`FCPM_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid, "result request dropped while stalled")
	`FCPM_ASSERT_NEXT(a_payload_held, result_valid && !result_ready, $stable(red) && $stable(green) && $stable(blue) && $stable(color_index), "result payload changed while stalled")
	`FCPM_ASSERT_IMP(a_index_range, result_valid, color_index <= IDX_W'(PALETTE_SIZE), "palette index above saturation")
	`FCPM_ASSERT_IMP(a_zero_start, result_valid && color_index == '0, red == green && green == blue, "index zero did not give the start colour")
	`FCPM_ASSERT_IMP(a_top_end, result_valid && color_index == IDX_W'(PALETTE_SIZE), red == blue && green == '0, "top index did not give the end colour")

endmodule

bind false_color_pixel_mapper fcpm_checker u_fcpm_checker (.*);
